FILE: sv/bf3em_pkg.sv
// Shared constants, control/status structs and the reciprocal table of the
// 3x3 edge-clipped box filter. No dependencies.
`default_nettype none

package bf3em_pkg;

    // Line store depth and derived address width
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int RAM_AW     = $clog2(MAX_WIDTH);

    // Field widths
    localparam int PIX_W = 8;
    localparam int COL_W = 10;
    localparam int ROW_W = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int CFGW_W     = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Mean arithmetic: sum of up to nine pixels, count 1..9
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Up to four results per input word, selected by {row_is_cur, col_is_cur}
    localparam int RES_N = 4;
    localparam int SEL_W = 2;

    typedef struct packed {
        logic             take;
        logic             shift;
        logic             sum_en;
        logic             mul_en;
        logic             out_load;
        logic [SEL_W-1:0] sel;
        logic             last;
    } dp_cmd_t;

    typedef struct packed {
        logic [RES_N-1:0] res_mask;
        logic             out_free;
    } dp_status_t;

    // ceil(2^16 / cnt); exact truncated quotient for any sum below 2296
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/bf3em_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bf3em_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/bf3em_ctrl.sv
// Sequencer of the box filter: input handshake and result scheduling.
// Depends on bf3em_pkg.
`default_nettype none

module bf3em_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire bf3em_pkg::dp_status_t  status,
    output bf3em_pkg::dp_cmd_t          cmd
);

    import bf3em_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [RES_N-1:0] pend_reg, pend_next;
    logic [SEL_W-1:0] k;
    logic [RES_N-1:0] k_bit;
    logic [RES_N-1:0] remain;

    // Pick the lowest pending result
    always_comb
    begin
        priority if (pend_reg[0]) k = 2'd0;
        else if (pend_reg[1])     k = 2'd1;
        else if (pend_reg[2])     k = 2'd2;
        else                      k = 2'd3;
        k_bit  = RES_N'(1) << k;
        remain = pend_reg & ~k_bit;
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        cmd          = '0;
        cmd.sel      = k;
        cmd.last     = (remain == '0);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                pend_next  = status.res_mask;
                state_next = (status.res_mask == '0) ? ST_IDLE : ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    pend_next    = remain;
                    state_next   = (remain == '0) ? ST_IDLE : ST_SUM;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bf3em_datapath.sv
// Datapath of the box filter: configuration, counters, line store RAM,
// 3x3 window, masked sum, reciprocal multiply and output register.
// Depends on bf3em_pkg and bf3em_ram.
`default_nettype none

module bf3em_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire bf3em_pkg::dp_cmd_t                  cmd,
    output bf3em_pkg::dp_status_t                    status,
    input  wire logic [bf3em_pkg::PIX_W-1:0]         pixel_in,
    input  wire logic                                cfg_we,
    input  wire logic [bf3em_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bf3em_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic      [bf3em_pkg::ROW_W-1:0]         out_row,
    output logic      [bf3em_pkg::COL_W-1:0]         out_column,
    output logic      [bf3em_pkg::PIX_W-1:0]         smoothed_value,
    output logic                                     last_of_run,
    output logic                                     frame_done
);

    import bf3em_pkg::*;

    // Configuration: width and height minus one, already clamped
    logic [COL_W-1:0]  wm1_reg;
    logic [ROW_W-1:0]  hm1_reg;
    logic [CFGW_W-1:0] raw_w;
    logic [CFG_DATA_W-1:0] raw_h;
    logic [COL_W-1:0]  wm1_next;
    logic [ROW_W-1:0]  hm1_next;

    // Counters and per-word step state
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] c_cur, c_reg;
    logic [ROW_W-1:0] r_cur, r_reg;
    logic             wrap, c_last, r_last;
    logic             r_ge1_reg, r_ge2_reg, c_ge1_reg, c_ge2_reg;
    logic [RES_N-1:0] mask_reg, mask_next;
    logic [PIX_W-1:0] pix_reg;

    // Line stores: upper in the high byte, middle in the low byte
    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] ram_wdata;

    // Window, sum and mean
    logic [PIX_W-1:0]  win_reg [3][3];
    logic [2:0]        row_ok, col_ok;
    logic [PIX_W+1:0]  row_sum [3];
    logic [SUM_W-1:0]  sum_next, sum_reg;
    logic [8:0]        cell_ok;
    logic [CNT_W-1:0]  cnt_next, cnt_reg;
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  mean_reg;

    // Clamp register writes to the usable range
    always_comb
    begin
        raw_w = cfg_data[CFGW_W-1:0];
        raw_h = cfg_data;
        if (raw_w == '0)
            wm1_next = '0;
        else if (raw_w > CFGW_W'(MAX_WIDTH))
            wm1_next = COL_W'(MAX_WIDTH - 1);
        else
            wm1_next = COL_W'(raw_w - CFGW_W'(1));
        if (raw_h == '0)
            hm1_next = '0;
        else if (raw_h > CFG_DATA_W'(MAX_HEIGHT))
            hm1_next = ROW_W'(MAX_HEIGHT - 1);
        else
            hm1_next = ROW_W'(raw_h - CFG_DATA_W'(1));
    end

    // Position of the incoming word and counter advance
    always_comb
    begin
        wrap   = (col_cnt_reg > wm1_reg) || (row_cnt_reg > hm1_reg);
        c_cur  = wrap ? '0 : col_cnt_reg;
        r_cur  = wrap ? '0 : row_cnt_reg;
        c_last = (c_cur == wm1_reg);
        r_last = (r_cur == hm1_reg);
        if (c_last)
        begin
            col_cnt_next = '0;
            row_cnt_next = r_last ? '0 : r_cur + ROW_W'(1);
        end
        else
        begin
            col_cnt_next = c_cur + COL_W'(1);
            row_cnt_next = r_cur;
        end
        mask_next[0] = (r_cur != '0) && (c_cur != '0);
        mask_next[1] = (r_cur != '0) && c_last;
        mask_next[2] = r_last && (c_cur != '0);
        mask_next[3] = r_last && c_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg     <= COL_W'(MAX_WIDTH - 1);
            hm1_reg     <= ROW_W'(1023);
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            mask_reg    <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_FRAME_WIDTH))
                wm1_reg <= wm1_next;
            if (cfg_we && (cfg_index == CFG_FRAME_HEIGHT))
                hm1_reg <= hm1_next;
            if (cmd.take)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
                mask_reg    <= mask_next;
            end
        end
    end

    // Capture the word and its position
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pix_reg   <= pixel_in;
            c_reg     <= c_cur;
            r_reg     <= r_cur;
            r_ge1_reg <= (r_cur != '0);
            r_ge2_reg <= (r_cur > ROW_W'(1));
            c_ge1_reg <= (c_cur != '0);
            c_ge2_reg <= (c_cur > COL_W'(1));
        end
    end

    // Line store RAM: read at take, rotate rows at shift
    assign ram_wdata = {ram_rdata[PIX_W-1:0], pix_reg};

    bf3em_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (c_reg[RAM_AW-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.take),
        .raddr (c_cur[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Advance the window by one column
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= ram_rdata[2*PIX_W-1:PIX_W];
            win_reg[1][2] <= ram_rdata[PIX_W-1:0];
            win_reg[2][2] <= pix_reg;
        end
    end

    // Masked neighborhood sum for the selected target
    always_comb
    begin
        row_ok[0] = !cmd.sel[1] && r_ge2_reg;
        row_ok[1] = r_ge1_reg;
        row_ok[2] = 1'b1;
        col_ok[0] = !cmd.sel[0] && c_ge2_reg;
        col_ok[1] = c_ge1_reg;
        col_ok[2] = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            row_sum[i] = (col_ok[0] ? (PIX_W+2)'(win_reg[i][0]) : '0)
                       + (col_ok[1] ? (PIX_W+2)'(win_reg[i][1]) : '0)
                       + (col_ok[2] ? (PIX_W+2)'(win_reg[i][2]) : '0);
            for (int j = 0; j < 3; j++)
            begin
                cell_ok[3*i+j] = row_ok[i] && col_ok[j];
            end
        end
        sum_next = (row_ok[0] ? SUM_W'(row_sum[0]) : '0)
                 + (row_ok[1] ? SUM_W'(row_sum[1]) : '0)
                 + (row_ok[2] ? SUM_W'(row_sum[2]) : '0);
        cnt_next = CNT_W'($countones(cell_ok));
    end

    assign prod = PROD_W'(sum_reg) * PROD_W'(recip(cnt_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
        if (cmd.mul_en)
        begin
            mean_reg <= prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
        end
    end

    // Output register: load when free, drop valid when taken
    assign status.out_free = !out_valid || out_ready;
    assign status.res_mask = mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_row        <= cmd.sel[1] ? r_reg : r_reg - ROW_W'(1);
            out_column     <= cmd.sel[0] ? c_reg : c_reg - COL_W'(1);
            smoothed_value <= mean_reg;
            last_of_run    <= cmd.last;
            frame_done     <= (cmd.sel == 2'd3);
        end
    end

endmodule

`default_nettype wire

FILE: sv/box_filter_3x3_edge_mean_top.sv
// 3x3 box filter with border clipping over a raster pixel stream.
//
// Input channel: in_valid/in_ready with pixel_in, one word per pixel in
// raster order. Output channel: out_valid/out_ready with out_row,
// out_column, smoothed_value, last_of_run and frame_done. Each result is
// the truncated mean of the in-frame 3x3 neighbors of one pixel; results
// lag one row and one column. A pixel causes 0 to 4 results; last_of_run
// marks the last of them and frame_done the final result of the frame.
// Configuration: cfg_we, cfg_index (0 frame_width, 1 frame_height),
// cfg_data; write only while idle. Out-of-range values are clamped.
// Sequence: after a pixel is accepted, the input stays blocked through the
// RAM read, window shift, then sum, reciprocal multiply and output load
// per result; the first result is valid after shift, sum, multiply, load.
// The output register lets the next pixel be accepted while the last
// result waits. A stalled receiver holds the sequencer at output load.
// Reset clears counters, restores 1024x1024 and empties the output; the
// line store RAM is not cleared, its stale entries only feed neighbors
// outside the frame.
`default_nettype none

module box_filter_3x3_edge_mean_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [bf3em_pkg::PIX_W-1:0]         pixel_in,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [bf3em_pkg::ROW_W-1:0]         out_row,
    output logic      [bf3em_pkg::COL_W-1:0]         out_column,
    output logic      [bf3em_pkg::PIX_W-1:0]         smoothed_value,
    output logic                                     last_of_run,
    output logic                                     frame_done,
    input  wire logic                                cfg_we,
    input  wire logic [bf3em_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bf3em_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import bf3em_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bf3em_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bf3em_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .pixel_in       (pixel_in),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_row        (out_row),
        .out_column     (out_column),
        .smoothed_value (smoothed_value),
        .last_of_run    (last_of_run),
        .frame_done     (frame_done)
    );

`ifndef SYNTH
    // An accepted word blocks the input for at least the next cycle
    a_take_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in consecutive cycles");

    // The end-of-frame result closes its run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> last_of_run)
        else $error("frame_done without last_of_run");

    // The sequencer loads the output only when it is free
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire
